FILE: rtl/cfht_pkg.sv
// ----------------------------------------------------------------------------
// cfht_pkg: shared types and constants for the complex FIR filter
// Holds the field widths, operation and register codes, and the control states.
// ----------------------------------------------------------------------------
package cfht_pkg;

	// Fixed widths of the port fields.
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 40;
	localparam int IDX_W   = 4;
	localparam int OS_W    = 4;
	localparam int TAPS_W  = 5;
	localparam int CFG_W   = 5;

	// Operation codes carried by the opcode field.
	typedef enum logic [0:0] {
		OP_FILTER = 1'b0,
		OP_LOAD   = 1'b1
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_OVERSAMPLE = 1'b0,
		REG_TAPS_USED  = 1'b1
	} reg_index_t;

	// Control states of the filter sequencer.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOCATE,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

endpackage

FILE: rtl/cfht_cell.sv
// ----------------------------------------------------------------------------
// cfht_cell: one delay line cell
// Holds one complex sample and, when the ring turns, takes its neighbour's
// sample, or the feedback sample when it is the last cell of the ring.
// ----------------------------------------------------------------------------
module cfht_cell #(
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic              is_last,
	input  logic [DATA_W-1:0] nb_data,
	input  logic [DATA_W-1:0] fb_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	// The sample moves one place towards the head on every shift of the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= is_last ? fb_data : nb_data;
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/cfht_mac.sv
// ----------------------------------------------------------------------------
// cfht_mac: complex multiply-accumulate unit
// Registers the four partial products, then adds them into the two
// accumulators, wrapping at the output width.
// ----------------------------------------------------------------------------
module cfht_mac
	import cfht_pkg::*;
#(
	parameter int SB = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    valid,
	input  logic signed [SB-1:0]    a_re,
	input  logic signed [SB-1:0]    a_im,
	input  logic signed [SB-1:0]    b_re,
	input  logic signed [SB-1:0]    b_im,
	output logic                    busy,
	output logic signed [SUM_W-1:0] acc_re,
	output logic signed [SUM_W-1:0] acc_im
);

	localparam int PW = 2 * SB;

	logic                    valid_s1;
	logic signed [PW-1:0]    rr_s1, ii_s1, ri_s1, ir_s1;
	logic signed [SUM_W-1:0] acc_re_q, acc_im_q;

	// Product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		rr_s1 <= b_re * a_re;
		ii_s1 <= b_im * a_im;
		ri_s1 <= b_re * a_im;
		ir_s1 <= b_im * a_re;
	end

	// Accumulate stage; cleared at the start of each sample.
	always_ff @(posedge clk) begin
		if (clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (valid_s1) begin
			acc_re_q <= acc_re_q + SUM_W'(rr_s1) - SUM_W'(ii_s1);
			acc_im_q <= acc_im_q + SUM_W'(ri_s1) + SUM_W'(ir_s1);
		end
	end

	assign busy   = valid_s1;
	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;

endmodule

FILE: rtl/complex_fir_held_taps.sv
// ----------------------------------------------------------------------------
// complex_fir_held_taps: complex FIR filter with held coefficients
// Channel  Handshake            Payload
// in       in_valid/in_stall    opcode, coef_index, value_re, value_im
// out      out_valid/out_stall  sum_re, sum_im
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A coefficient load is written when its transfer is taken. A sample first finds
// the coefficient of its first tap by repeated subtraction, then takes one tap per
// cycle (L = taps_used x oversample taps) while the ring of delay cells makes one
// full turn through the single complex multiply-accumulate unit, then drains it.
// Reset clears the delay cells, the coefficients and the write position.
// The result sits in an output register, so a stalled output only holds the
// next sample once its sum is ready.
// ----------------------------------------------------------------------------
module complex_fir_held_taps
	import cfht_pkg::*;
#(
	parameter int NUM_TAPS       = 16,
	parameter int MAX_OVERSAMPLE = 8,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  logic [IDX_W-1:0]        coef_index,
	input  logic signed [VALUE_W-1:0] value_re,
	input  logic signed [VALUE_W-1:0] value_im,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SUM_W-1:0] sum_re,
	output logic signed [SUM_W-1:0] sum_im,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int SB    = SAMPLE_BITS;
	localparam int DW    = 2 * SB;
	localparam int DEPTH = NUM_TAPS * MAX_OVERSAMPLE;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int CW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int OW    = $clog2(MAX_OVERSAMPLE + 1);
	localparam int TW    = $clog2(NUM_TAPS + 1);

	state_t state_q, state_d;

	logic [OS_W-1:0]   os_reg_q;
	logic [TAPS_W-1:0] taps_reg_q;
	logic [OW-1:0]     os_e;
	logic [TW-1:0]     taps_e;
	logic [LW-1:0]     len_c, len_q;
	logic [OW-1:0]     os_q;
	logic [PW-1:0]     wp_q, pos_q, pos_c;
	logic [PW-1:0]     k_q, j_q, rem_q;
	logic [CW-1:0]     c_q;
	logic [OW-1:0]     r_q;
	logic [DW-1:0]     new_q;
	logic [SB-1:0]     v_re, v_im;
	logic [SB-1:0]     coef_re_q [NUM_TAPS];
	logic [SB-1:0]     coef_im_q [NUM_TAPS];
	logic [DW-1:0]     cell_data [DEPTH];
	logic [DW-1:0]     fb_data;
	logic              in_xfer, sweep, last_tap, last_k, out_free;
	logic              mac_busy;
	logic signed [SUM_W-1:0] acc_re, acc_im;
	logic              out_valid_q;
	logic signed [SUM_W-1:0] sum_re_q, sum_im_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;

	// Configuration registers keep the written bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			os_reg_q   <= OS_W'(1);
			taps_reg_q <= TAPS_W'(16);
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_OVERSAMPLE: os_reg_q   <= cfg_data[OS_W-1:0];
				REG_TAPS_USED:  taps_reg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the registers into range and form the line length.
	always_comb begin
		if (os_reg_q == '0) begin
			os_e = OW'(1);
		end else if (32'(os_reg_q) > MAX_OVERSAMPLE) begin
			os_e = OW'(MAX_OVERSAMPLE);
		end else begin
			os_e = OW'(os_reg_q);
		end
		if (taps_reg_q == '0) begin
			taps_e = TW'(1);
		end else if (32'(taps_reg_q) > NUM_TAPS) begin
			taps_e = TW'(NUM_TAPS);
		end else begin
			taps_e = TW'(taps_reg_q);
		end
		len_c = LW'(32'(taps_e) * 32'(os_e));
		pos_c = (32'(wp_q) >= 32'(len_c)) ? '0 : wp_q;
	end

	// Value fields are read as SAMPLE_BITS-bit two's complement.
	assign v_re = SB'($unsigned(value_re));
	assign v_im = SB'($unsigned(value_im));

	// Coefficient store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				coef_re_q[i] <= '0;
				coef_im_q[i] <= '0;
			end
		end else if (in_xfer && opcode_t'(opcode) == OP_LOAD
				&& 32'(coef_index) < NUM_TAPS) begin
			coef_re_q[CW'(coef_index)] <= v_re;
			coef_im_q[CW'(coef_index)] <= v_im;
		end
	end

	// Sweep bookkeeping.
	assign sweep    = (state_q == ST_SWEEP);
	assign last_tap = (32'(j_q) == 32'(len_q) - 1);
	assign last_k   = (32'(k_q) == 32'(len_q) - 1);
	assign out_free = !out_valid_q || !out_stall;

	// The head cell shows line entry k; entry pos takes the new sample.
	assign fb_data = (k_q == pos_q) ? new_q : cell_data[0];

	// Ring of delay cells.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DW-1:0] nb;
		if (g == DEPTH - 1) begin : g_end
			assign nb = fb_data;
		end else begin : g_mid
			assign nb = cell_data[g+1];
		end
		cfht_cell #(.DATA_W(DW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (sweep && (g < 32'(len_q))),
			.is_last (g == 32'(len_q) - 1),
			.nb_data (nb),
			.fb_data (fb_data),
			.data    (cell_data[g])
		);
	end

	// Control state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && opcode_t'(opcode) == OP_FILTER) begin
					state_d = ST_LOCATE;
				end
			end
			ST_LOCATE: begin
				if (32'(rem_q) < 32'(os_q)) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Write position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (in_xfer && opcode_t'(opcode) == OP_FILTER) begin
			wp_q <= (32'(pos_c) + 1 == 32'(len_c)) ? '0 : PW'(32'(pos_c) + 1);
		end
	end

	// Per-sample counters: first tap index, then its coefficient by subtraction.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				len_q <= len_c;
				os_q  <= os_e;
				pos_q <= pos_c;
				new_q <= {v_re, v_im};
				rem_q <= PW'(32'(len_c) - 1 - 32'(pos_c));
				j_q   <= PW'(32'(len_c) - 1 - 32'(pos_c));
				c_q   <= '0;
				k_q   <= '0;
			end
			ST_LOCATE: begin
				if (32'(rem_q) >= 32'(os_q)) begin
					rem_q <= PW'(32'(rem_q) - 32'(os_q));
					c_q   <= c_q + CW'(1);
				end else begin
					r_q <= OW'(rem_q);
				end
			end
			ST_SWEEP: begin
				k_q <= k_q + PW'(1);
				if (last_tap) begin
					j_q <= '0;
					c_q <= '0;
					r_q <= '0;
				end else begin
					j_q <= j_q + PW'(1);
					if (32'(r_q) + 1 == 32'(os_q)) begin
						r_q <= '0;
						c_q <= c_q + CW'(1);
					end else begin
						r_q <= r_q + OW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Multiply-accumulate on the sample at the head of the ring.
	cfht_mac #(.SB(SB)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (state_q == ST_LOCATE),
		.valid  (sweep),
		.a_re   (fb_data[DW-1:SB]),
		.a_im   (fb_data[SB-1:0]),
		.b_re   (coef_re_q[c_q]),
		.b_im   (coef_im_q[c_q]),
		.busy   (mac_busy),
		.acc_re (acc_re),
		.acc_im (acc_im)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DRAIN && !mac_busy && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && !mac_busy && out_free) begin
			sum_re_q <= acc_re;
			sum_im_q <= acc_im;
		end
	end

	assign out_valid = out_valid_q;
	assign sum_re    = sum_re_q;
	assign sum_im    = sum_im_q;

endmodule

FILE: test/tb_complex_fir_held_taps.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_fir_held_taps: self-checking bench for the complex FIR filter
// A directed table of loads and samples runs first. Random phases follow under
// many oversample and taps_used settings, including out-of-range ones. Every
// sum is predicted by a behavioural model of the held-tap filter kept in the
// bench or given by the table for a typed row, checked field by field on output.
// ----------------------------------------------------------------------------
module tb_complex_fir_held_taps;
	import cfht_pkg::*;

	localparam int  LINE_DEPTH  = 128;
	localparam int  COEF_SLOTS  = 16;
	localparam int  SETTLE      = 200;
	localparam int  CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [SUM_W-1:0] re;
		logic signed [SUM_W-1:0] im;
	} csum_t;

	typedef struct {
		opcode_t                   op;
		logic [IDX_W-1:0]          idx;
		logic signed [VALUE_W-1:0] re;
		logic signed [VALUE_W-1:0] im;
		bit                        typed;
		longint                    sum_re;
		longint                    sum_im;
	} row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      opcode = 1'b0;
	logic [IDX_W-1:0]          coef_index = '0;
	logic signed [VALUE_W-1:0] value_re = '0;
	logic signed [VALUE_W-1:0] value_im = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [SUM_W-1:0]   sum_re;
	logic signed [SUM_W-1:0]   sum_im;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_index = 1'b0;
	logic [CFG_W-1:0]          cfg_data = '0;

	// Filter state mirrored in the bench.
	longint       line_re [LINE_DEPTH];
	longint       line_im [LINE_DEPTH];
	longint       tap_re [COEF_SLOTS];
	longint       tap_im [COEF_SLOTS];
	int unsigned  wr_pos;
	logic [3:0]   os_reg;
	logic [4:0]   taps_reg;

	csum_t pending_sums [$];
	int    fails = 0;
	bit    quiet = 1'b0;
	bit    hold_req = 1'b0;
	int    cyc = 0;

	complex_fir_held_taps dut (.*);

	always #5 clk = ~clk;

	// Apply one item to the mirrored filter; returns 1 when it yields a sum.
	function automatic bit fir_apply(input logic op, input logic [3:0] idx,
			input longint re, input longint im, output csum_t sum);
		int unsigned os, taps, len, pos, c;
		longint acc_re, acc_im;
		acc_re = 0;
		acc_im = 0;
		if (op == OP_LOAD) begin
			tap_re[idx] = re;
			tap_im[idx] = im;
			return 1'b0;
		end
		os = (os_reg == 0) ? 1 : (os_reg > 8) ? 8 : os_reg;
		taps = (taps_reg == 0) ? 1 : (taps_reg > 16) ? 16 : taps_reg;
		len = os * taps;
		pos = (wr_pos >= len) ? 0 : wr_pos;
		line_re[pos] = re;
		line_im[pos] = im;
		pos = (pos + 1 >= len) ? 0 : pos + 1;
		wr_pos = pos;
		for (int unsigned j = 0; j < len; j++) begin
			c = j / os;
			acc_re += tap_re[c] * line_re[pos] - tap_im[c] * line_im[pos];
			acc_im += tap_re[c] * line_im[pos] + tap_im[c] * line_re[pos];
			pos = (pos + 1 >= len) ? 0 : pos + 1;
		end
		sum.re = acc_re[SUM_W-1:0];
		sum.im = acc_im[SUM_W-1:0];
		return 1'b1;
	endfunction

	// Idle cycles before the next transfer: mostly none, sometimes long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item and wait for its transfer; record the expected sum.
	task automatic send_item(input opcode_t op, input logic [3:0] idx,
			input logic signed [15:0] re, input logic signed [15:0] im,
			input bit typed, input longint t_re, input longint t_im);
		int    gap;
		csum_t sum;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		coef_index <= idx;
		value_re   <= re;
		value_im   <= im;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (fir_apply(op, idx, re, im, sum)) begin
			if (typed) begin
				sum.re = t_re[SUM_W-1:0];
				sum.im = t_im[SUM_W-1:0];
			end
			pending_sums.push_back(sum);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write; only called while the filter is idle.
	task automatic write_reg(input reg_index_t ri, input logic [4:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (ri == REG_OVERSAMPLE) os_reg = data[3:0];
		else taps_reg = data;
		@(posedge clk);
	endtask

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (int k = 0; k < 400; k++) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 4) stall_left = $urandom_range(10, 60);
				out_stall <= (r < 30);
			end
		end
	end

	// Compare each sum transfer with the oldest expectation.
	always @(posedge clk) begin
		csum_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$error("sum transfer with none expected: re %0d im %0d", sum_re, sum_im);
				fails++;
			end else begin
				want = pending_sums.pop_front();
				if (sum_re !== want.re) begin
					$error("sum_re: expected %0d, got %0d", want.re, sum_re);
					fails++;
				end
				if (sum_im !== want.im) begin
					$error("sum_im: expected %0d, got %0d", want.im, sum_im);
					fails++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		row_t rows [] = '{
			'{OP_FILTER, 4'd0, 16'sd100, -16'sd200, 1'b1, 0, 0},
			'{OP_LOAD, 4'd0, 16'sd32767, 16'sd0, 1'b0, 0, 0},
			'{OP_LOAD, 4'd15, -16'sd32768, -16'sd32768, 1'b0, 0, 0},
			'{OP_LOAD, 4'd7, -16'sd32768, 16'sd32767, 1'b0, 0, 0},
			'{OP_FILTER, 4'd0, -16'sd32768, -16'sd32768, 1'b0, 0, 0},
			'{OP_FILTER, 4'd9, 16'sd32767, 16'sd32767, 1'b0, 0, 0},
			'{OP_FILTER, 4'd0, 16'sd0, -16'sd32768, 1'b0, 0, 0},
			'{OP_LOAD, 4'd15, 16'sd32767, -16'sd1, 1'b0, 0, 0},
			'{OP_FILTER, 4'd0, -16'sd1, 16'sd1, 1'b0, 0, 0},
			'{OP_LOAD, 4'd3, 16'sh5555, -16'sh5556, 1'b0, 0, 0},
			'{OP_FILTER, 4'd15, 16'sh2AAA, 16'sh5555, 1'b0, 0, 0},
			'{OP_FILTER, 4'd0, 16'sd32767, -16'sd32768, 1'b0, 0, 0}
		};
		// Register settings per random phase: extremes, out of range, random.
		logic [4:0] os_set [] = '{5'd8, 5'd1, 5'd0, 5'd15, 5'd24, 5'd3, 5'd8, 5'd5, 5'd2, 5'd8};
		logic [4:0] tp_set [] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7, 5'd1, 5'd16, 5'd12, 5'd4};
		int count;

		for (int k = 0; k < LINE_DEPTH; k++) begin
			line_re[k] = 0;
			line_im[k] = 0;
		end
		for (int k = 0; k < COEF_SLOTS; k++) begin
			tap_re[k] = 0;
			tap_im[k] = 0;
		end
		wr_pos = 0;
		os_reg = 4'd1;
		taps_reg = 5'd16;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset settings.
		foreach (rows[i])
			send_item(rows[i].op, rows[i].idx, rows[i].re, rows[i].im,
				rows[i].typed, rows[i].sum_re, rows[i].sum_im);
		drain();

		// Random phases, each under its own register setting.
		foreach (os_set[p]) begin
			write_reg(REG_OVERSAMPLE, (p == 5) ? 5'($urandom_range(0, 31)) : os_set[p]);
			write_reg(REG_TAPS_USED, (p == 8) ? 5'($urandom_range(0, 31)) : tp_set[p]);
			quiet = (p == 3);
			count = 0;
			while (count < 54) begin
				if (count == 20 && p == 1) hold_req = 1'b1;
				if (count == 30 && p == 6) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_sums.size() != 0) @(posedge clk);
				end
				if ($urandom_range(0, 99) < 25)
					send_item(OP_LOAD, 4'($urandom_range(0, 15)),
						16'($urandom), 16'($urandom), 1'b0, 0, 0);
				else
					send_item(OP_FILTER, 4'($urandom_range(0, 15)),
						16'($urandom), 16'($urandom), 1'b0, 0, 0);
				count++;
			end
			drain();
		end

		if (pending_sums.size() != 0) begin
			$error("%0d expected sums never arrived", pending_sums.size());
			fails++;
		end
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
